/* rtl/core/rtog_pkg.sv */
// ----------------------------------------------------------------------------
// rtog_pkg
// types, constants and helpers shared by the occupancy grid ray tracer
// ----------------------------------------------------------------------------
package rtog_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int COUNT_BITS_DEF = 16;

   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int DIM_BITS = 9;
   localparam int COORD_BITS = 16;
   localparam int OUT_BITS = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_TRACE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic [1:0] CLASS_UNKNOWN  = 2'd0;
   localparam logic [1:0] CLASS_FREE     = 2'd1;
   localparam logic [1:0] CLASS_OCCUPIED = 2'd2;

   localparam logic [1:0] CSR_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_OCC_THR  = 2'd2;
   localparam logic [1:0] CSR_FREE_THR = 2'd3;

   localparam logic [8:0]  WIDTH_RST    = 9'd256;
   localparam logic [8:0]  HEIGHT_RST   = 9'd256;
   localparam logic [15:0] OCC_THR_RST  = 16'd42598;
   localparam logic [15:0] FREE_THR_RST = 16'd16384;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
   } req_type;

   typedef struct packed {
      logic [1:0]  cell_class;
      logic [15:0] hit_count;
      logic [15:0] miss_count;
   } rsp_type;

   typedef struct packed {
      logic [8:0]  grid_width;
      logic [8:0]  grid_height;
      logic [15:0] occ_thr;
      logic [15:0] free_thr;
   } cfg_type;

endpackage

/* rtl/core/rtog_ram.sv */
// ----------------------------------------------------------------------------
// rtog_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rtog_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/rtog_front.sv */
// ----------------------------------------------------------------------------
// rtog_front
// accepts commands and queues them for the walker, which works out the ray deltas and steps
// ----------------------------------------------------------------------------
module rtog_front
   import rtog_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   input  logic    clear_busy,
   output logic    q_valid,
   output req_type q_item,
   input  logic    q_pop,
   output logic    q_empty
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   req_type               q_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     cnt_ff, cnt_in;
   logic                  push;

   assign busy = clear_busy || (cnt_ff == PTR_BITS'(0) + (PTR_BITS+1)'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign q_valid = (cnt_ff != '0);
   assign q_empty = (cnt_ff == '0);
   assign q_item = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_BITS'(1);
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + (PTR_BITS+1)'(1);
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - (PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= req;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == (PTR_BITS+1)'(QUEUE_DEPTH)) |-> busy) else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (cnt_ff == $past(cnt_ff) + (PTR_BITS+1)'(1)))
      else $error("queue count lost a push");

endmodule

/* rtl/core/rtog_back.sv */
// ----------------------------------------------------------------------------
// rtog_back
// walks a ray one cell per step with read-modify-write on the count stores,
// serves reads and sweeps clears
// ----------------------------------------------------------------------------
module rtog_back
   import rtog_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_valid,
   input  req_type q_item,
   output logic    q_pop,
   output logic    clear_busy,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   localparam int XB = $clog2(MAX_WIDTH);
   localparam int YB = $clog2(MAX_HEIGHT);
   localparam int AB = XB + YB;
   localparam int DEPTH = 1 << AB;
   localparam int CB = 18;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] OUT_MAX = COUNT_BITS'(16'hFFFF);
   localparam int WB = (XB > YB ? XB : YB) + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD    = 3'd1;
   localparam logic [2:0] ST_WR    = 3'd2;
   localparam logic [2:0] ST_QRD   = 3'd3;
   localparam logic [2:0] ST_QCMP  = 3'd4;
   localparam logic [2:0] ST_CLR   = 3'd5;
   localparam logic [2:0] ST_MUL   = 3'd6;
   localparam logic [2:0] ST_FIN   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic signed [CB-1:0] x_ff, x_in, y_ff, y_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [CB-1:0] dx_ff, dx_in, dy_ff, dy_in, err_ff, err_in;
   logic sx_ff, sx_in, sy_ff, sy_in, last_ff, last_in, in_ff, in_in;
   logic init_ff, init_in;
   logic [AB-1:0] addr_ff, addr_in;
   logic [AB:0] clr_ff, clr_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;
   logic [COUNT_BITS:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] h_ff, h_in, m_ff, m_in;
   logic [COUNT_BITS+16:0] ho_ff, ho_in, occp_ff, occp_in, frep_ff, frep_in;

   logic hit_we, miss_we;
   logic [AB-1:0] wa;
   logic [COUNT_BITS-1:0] hit_wd, miss_wd, hit_rd, miss_rd;

   logic [WB-1:0] w_lim, h_lim;
   logic cur_in_grid, rd_in_grid;
   logic signed [CB-1:0] twice, adx, ady;
   logic at_end;

   rtog_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_hit (
      .clock(clock), .wr_en(hit_we), .wr_addr(wa), .wr_data(hit_wd),
      .rd_addr(addr_in), .rd_data(hit_rd));
   rtog_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_miss (
      .clock(clock), .wr_en(miss_we), .wr_addr(wa), .wr_data(miss_wd),
      .rd_addr(addr_in), .rd_data(miss_rd));

   function automatic logic in_grid(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                                    input logic [WB-1:0] wl, input logic [WB-1:0] hl);
      logic ok;
      ok = !x[CB-1] && !y[CB-1] && (x < $signed({1'b0, (CB-1)'(wl)}))
           && (y < $signed({1'b0, (CB-1)'(hl)}));
      return ok;
   endfunction

   function automatic logic [AB-1:0] addr_of(input logic signed [CB-1:0] x,
                                             input logic signed [CB-1:0] y);
      return {y[YB-1:0], x[XB-1:0]};
   endfunction

   always_comb begin
      w_lim = (int'(cfg.grid_width) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(cfg.grid_width);
      h_lim = (int'(cfg.grid_height) > MAX_HEIGHT) ? WB'(MAX_HEIGHT) : WB'(cfg.grid_height);
   end

   assign cur_in_grid = in_grid(x_ff, y_ff, w_lim, h_lim);
   assign at_end = (x_ff == ex_ff) && (y_ff == ey_ff);
   assign twice = err_ff <<< 1;
   assign rd_in_grid = in_grid(CB'(q_item.end_x), CB'(q_item.end_y), w_lim, h_lim);
   assign adx = (CB'(q_item.end_x) > CB'(q_item.start_x)) ?
                CB'(q_item.end_x) - CB'(q_item.start_x) : CB'(q_item.start_x) - CB'(q_item.end_x);
   assign ady = (CB'(q_item.end_y) > CB'(q_item.start_y)) ?
                CB'(q_item.end_y) - CB'(q_item.start_y) : CB'(q_item.start_y) - CB'(q_item.end_y);

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; ex_in = ex_ff; ey_in = ey_ff;
      dx_in = dx_ff; dy_in = dy_ff; err_in = err_ff;
      sx_in = sx_ff; sy_in = sy_ff; last_in = last_ff; in_in = in_ff;
      init_in = init_ff;
      addr_in = addr_ff; clr_in = clr_ff;
      rsp_strobe_in = 1'b0; rsp_in = '0;
      total_in = total_ff; h_in = h_ff; m_in = m_ff;
      ho_in = ho_ff; occp_in = occp_ff; frep_in = frep_ff;
      q_pop = 1'b0;
      hit_we = 1'b0; miss_we = 1'b0; wa = addr_ff;
      hit_wd = '0; miss_wd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.cmd)
                  CMD_TRACE: begin
                     x_in = CB'(q_item.start_x); y_in = CB'(q_item.start_y);
                     ex_in = CB'(q_item.end_x); ey_in = CB'(q_item.end_y);
                     dx_in = adx; dy_in = -ady; err_in = adx - ady;
                     sx_in = CB'(q_item.start_x) < CB'(q_item.end_x);
                     sy_in = CB'(q_item.start_y) < CB'(q_item.end_y);
                     last_in = (q_item.start_x == q_item.end_x)
                               && (q_item.start_y == q_item.end_y);
                     in_in = in_grid(CB'(q_item.start_x), CB'(q_item.start_y), w_lim, h_lim);
                     addr_in = addr_of(CB'(q_item.start_x), CB'(q_item.start_y));
                     state_in = ST_RD;
                  end
                  CMD_READ: begin
                     in_in = rd_in_grid;
                     addr_in = addr_of(CB'(q_item.end_x), CB'(q_item.end_y));
                     state_in = ST_QRD;
                  end
                  CMD_CLEAR: begin
                     clr_in = '0;
                     state_in = ST_CLR;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            wa = addr_ff;
            if (last_ff) begin
               hit_we = in_ff && (hit_rd != CNT_MAX);
               hit_wd = hit_rd + COUNT_BITS'(1);
               rsp_strobe_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               miss_we = in_ff && (miss_rd != CNT_MAX);
               miss_wd = miss_rd + COUNT_BITS'(1);
               if (twice >= dy_ff) begin
                  x_in = sx_ff ? x_ff + CB'(1) : x_ff - CB'(1);
               end
               if (twice <= dx_ff) begin
                  y_in = sy_ff ? y_ff + CB'(1) : y_ff - CB'(1);
               end
               err_in = err_ff + ((twice >= dy_ff) ? dy_ff : CB'(0))
                        + ((twice <= dx_ff) ? dx_ff : CB'(0));
               last_in = (x_in == ex_ff) && (y_in == ey_ff);
               in_in = in_grid(x_in, y_in, w_lim, h_lim);
               addr_in = addr_of(x_in, y_in);
               state_in = ST_RD;
            end
         end
         ST_QRD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            h_in = hit_rd; m_in = miss_rd;
            total_in = {1'b0, hit_rd} + {1'b0, miss_rd};
            state_in = ST_QCMP;
         end
         ST_QCMP: begin
            ho_in = (COUNT_BITS+17)'({h_ff, 16'd0});
            occp_in = (COUNT_BITS+17)'(cfg.occ_thr) * (COUNT_BITS+17)'(total_ff);
            frep_in = (COUNT_BITS+17)'(cfg.free_thr) * (COUNT_BITS+17)'(total_ff);
            state_in = ST_FIN;
         end
         ST_CLR: begin
            clr_in = clr_ff + (AB+1)'(1);
            wa = clr_ff[AB-1:0];
            hit_we = 1'b1; miss_we = 1'b1;
            if (clr_ff == (AB+1)'(DEPTH - 1)) begin
               rsp_strobe_in = !init_ff;
               init_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_FIN: begin
            rsp_strobe_in = 1'b1;
            state_in = ST_IDLE;
            if (in_ff) begin
               rsp_in.hit_count = (h_ff > OUT_MAX) ? 16'hFFFF : OUT_BITS'(h_ff);
               rsp_in.miss_count = (m_ff > OUT_MAX) ? 16'hFFFF : OUT_BITS'(m_ff);
               if (total_ff == '0) begin
                  rsp_in.cell_class = CLASS_UNKNOWN;
               end else if (ho_ff >= occp_ff) begin
                  rsp_in.cell_class = CLASS_OCCUPIED;
               end else if (ho_ff <= frep_ff) begin
                  rsp_in.cell_class = CLASS_FREE;
               end else begin
                  rsp_in.cell_class = CLASS_UNKNOWN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         clr_ff <= '0;
         init_ff <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         init_ff <= init_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      x_ff <= x_in; y_ff <= y_in; ex_ff <= ex_in; ey_ff <= ey_in;
      dx_ff <= dx_in; dy_ff <= dy_in; err_ff <= err_in;
      sx_ff <= sx_in; sy_ff <= sy_in; last_ff <= last_in; in_ff <= in_in;
      addr_ff <= addr_in; rsp_ff <= rsp_in;
      total_ff <= total_in; h_ff <= h_in; m_ff <= m_in;
      ho_ff <= ho_in; occp_ff <= occp_in; frep_ff <= frep_in;
   end

   assign clear_busy = (state_ff == ST_CLR);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (hit_we && miss_we) |-> (state_ff == ST_CLR)) else $error("both stores written outside clear");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE)) else $error("pop while walking");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR && last_ff) |=> rsp_strobe) else $error("trace without result");

endmodule

/* rtl/core/ray_trace_occupancy_grid.sv */
// ----------------------------------------------------------------------------
// ray_trace_occupancy_grid
// occupancy grid update by line tracing with hit and miss counters per cell
// ----------------------------------------------------------------------------
// channel   ports                         direction
// command   start, busy, req               in, one transaction when start && !busy
// result    rsp_strobe, rsp               out, one cycle, cannot be stalled
// csr       csr_valid, csr_ready, csr_*   in, write when valid && ready
//
// a trace visits each cell with a ram read state then a write state
// a read passes through ST_QRD, ST_MUL, ST_QCMP and ST_FIN; an unused command is answered from idle
// a clear and the pass after reset sweep every address of both count stores, busy held
// the pass after reset gives no result
// a two entry queue takes commands while the walker works
// ----------------------------------------------------------------------------
module ray_trace_occupancy_grid
   import rtog_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req,
   output logic                     rsp_strobe,
   output rsp_type                  rsp,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   cfg_type cfg_ff;
   logic    q_valid, q_pop, q_empty, clear_busy;
   req_type q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{WIDTH_RST, HEIGHT_RST, OCC_THR_RST, FREE_THR_RST};
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:    cfg_ff.grid_width <= csr_data[DIM_BITS-1:0];
            CSR_HEIGHT:   cfg_ff.grid_height <= csr_data[DIM_BITS-1:0];
            CSR_OCC_THR:  cfg_ff.occ_thr <= csr_data;
            CSR_FREE_THR: cfg_ff.free_thr <= csr_data;
            default: ;
         endcase
      end
   end

   rtog_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .clear_busy(clear_busy), .q_valid(q_valid), .q_item(q_item),
      .q_pop(q_pop), .q_empty(q_empty));

   rtog_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(q_valid), .q_item(q_item),
      .q_pop(q_pop), .clear_busy(clear_busy), .rsp_strobe(rsp_strobe), .rsp(rsp));

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp.cell_class != 2'd3)) else $error("bad class code");
   assert property (@(posedge clock) disable iff (reset)
      (q_empty && !start) |=> !q_pop) else $error("pop with no queued command");
   assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> busy) else $error("command taken during clear");

endmodule
